### src/positional_doubly_linked_list_macros.svh
// ----------------------------------------------------------------------------
// Positional doubly linked list assertion macros
// Concurrent assertion wrappers shared by the list modules.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_DOUBLY_LINKED_LIST_MACROS_SVH
`define POSITIONAL_DOUBLY_LINKED_LIST_MACROS_SVH

`ifndef SYNTHESIS

`define PDLL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define PDLL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`else

`define PDLL_ASSERT(label, clk, rst, prop, msg)

`define PDLL_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`endif

`endif

### src/pdll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional doubly linked list package
// Shared constants, operation and status codes, and inter-module structs.
// ----------------------------------------------------------------------------
package pdll_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int KIND_W           = 3;
   localparam int POS_W            = 8;
   localparam int VALUE_W          = 32;
   localparam int STATUS_W         = 3;
   localparam int REQ_DATA_W       = 40;
   localparam int RSP_DATA_W       = 40;

   typedef enum logic [KIND_W-1:0] {
      KIND_INS_HEAD = 3'd0,
      KIND_INS_TAIL = 3'd1,
      KIND_INS_AT   = 3'd2,
      KIND_DEL_HEAD = 3'd3,
      KIND_DEL_TAIL = 3'd4,
      KIND_DEL_AT   = 3'd5,
      KIND_UPDATE   = 3'd6,
      KIND_READ_ALL = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_INVALID = 3'd1,
      STATUS_RANGE   = 3'd2,
      STATUS_EMPTY   = 3'd3,
      STATUS_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      logic value;
      logic next;
      logic prev;
   } store_we_type;

   typedef struct packed {
      logic               load;
      status_type         status;
      logic               element_valid;
      logic [VALUE_W-1:0] element;
      logic               last;
   } rsp_type;

endpackage
`default_nettype wire

### src/pdll_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Node store
// Value, next-link and prev-link memories with one write port and one
// registered read port, each with its own node address.
// ----------------------------------------------------------------------------
module pdll_store #(
   parameter int  CAPACITY = pdll_pkg::CAPACITY_DEFAULT,
   localparam int LW       = $clog2(CAPACITY + 1),
   localparam int IW       = $clog2(CAPACITY)
) (
   input  logic                         clock,
   input  pdll_pkg::store_we_type       we,
   input  logic [IW-1:0]                wr_addr,
   input  logic [pdll_pkg::VALUE_W-1:0] wd_value,
   input  logic [LW-1:0]                wd_next,
   input  logic [LW-1:0]                wd_prev,
   input  logic [IW-1:0]                rd_addr,
   output logic [pdll_pkg::VALUE_W-1:0] rd_value,
   output logic [LW-1:0]                rd_next,
   output logic [LW-1:0]                rd_prev
);
   import pdll_pkg::*;

   logic [VALUE_W-1:0] value_mem [CAPACITY];
   logic [LW-1:0]      next_mem  [CAPACITY];
   logic [LW-1:0]      prev_mem  [CAPACITY];

   logic [VALUE_W-1:0] rd_value_ff;
   logic [LW-1:0]      rd_next_ff;
   logic [LW-1:0]      rd_prev_ff;

   always_ff @(posedge clock) begin
      if (we.value) begin
         value_mem[wr_addr] <= wd_value;
      end
      if (we.next) begin
         next_mem[wr_addr] <= wd_next;
      end
      if (we.prev) begin
         prev_mem[wr_addr] <= wd_prev;
      end
   end

   always_ff @(posedge clock) begin
      rd_value_ff <= value_mem[rd_addr];
      rd_next_ff  <= next_mem[rd_addr];
      rd_prev_ff  <= prev_mem[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_next_ff;
   assign rd_prev  = rd_prev_ff;

endmodule
`default_nettype wire

### src/pdll_freemap.sv
`timescale 1ns / 1ps
`default_nettype none
`include "positional_doubly_linked_list_macros.svh"
// ----------------------------------------------------------------------------
// Free node map
// One free bit per node, the lowest free node for allocation, and the count
// of nodes in use.
// ----------------------------------------------------------------------------
module pdll_freemap #(
   parameter int  CAPACITY = pdll_pkg::CAPACITY_DEFAULT,
   localparam int LW       = $clog2(CAPACITY + 1),
   localparam int IW       = $clog2(CAPACITY)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  logic          give,
   input  logic [IW-1:0] give_idx,
   output logic [IW-1:0] alloc_idx,
   output logic [LW-1:0] count,
   output logic          full
);
   import pdll_pkg::*;

   logic [CAPACITY-1:0] free_map_ff;
   logic [CAPACITY-1:0] free_map_in;
   logic [LW-1:0]       count_ff;
   logic [LW-1:0]       count_in;
   logic [CAPACITY-1:0] lowest;

   // Isolate the lowest set bit, then encode it.
   assign lowest = free_map_ff & (~free_map_ff + CAPACITY'(1));

   always_comb begin
      alloc_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (lowest[i]) begin
            alloc_idx = alloc_idx | IW'(i);
         end
      end
   end

   always_comb begin
      free_map_in = free_map_ff;
      count_in    = count_ff;
      if (take) begin
         free_map_in[alloc_idx] = 1'b0;
         count_in               = count_ff + LW'(1);
      end
      if (give) begin
         free_map_in[give_idx] = 1'b1;
         count_in              = count_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_map_ff <= '1;
         count_ff    <= '0;
      end else begin
         free_map_ff <= free_map_in;
         count_ff    <= count_in;
      end
   end

   assign count = count_ff;
   assign full  = (count_ff == LW'(CAPACITY));

   `PDLL_ASSERT(a_count_matches_map, clock, reset, count_ff == LW'(CAPACITY - $countones(free_map_ff)), "Node count disagrees with free map.")
   `PDLL_ASSERT_IMPL(a_take_not_full, clock, reset, take, free_map_ff != '0, "Allocation from a full store.")
   `PDLL_ASSERT_IMPL(a_give_in_use, clock, reset, give, !free_map_ff[give_idx], "Release of a node that is already free.")

endmodule
`default_nettype wire

### src/pdll_seq.sv
`timescale 1ns / 1ps
`default_nettype none
`include "positional_doubly_linked_list_macros.svh"
// ----------------------------------------------------------------------------
// List sequencer
// Decodes one operation, walks the links one node per cycle through the
// store read port, and performs the link updates one write per cycle.
// ----------------------------------------------------------------------------
module pdll_seq #(
   parameter int  CAPACITY = pdll_pkg::CAPACITY_DEFAULT,
   localparam int LW       = $clog2(CAPACITY + 1),
   localparam int IW       = $clog2(CAPACITY)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  pdll_pkg::kind_type           req_kind,
   input  logic [pdll_pkg::POS_W-1:0]   req_position,
   input  logic [pdll_pkg::VALUE_W-1:0] req_value,
   output logic                         ready,
   input  logic                         out_free,
   output pdll_pkg::rsp_type            rsp,
   input  logic [LW-1:0]                count,
   input  logic                         full,
   input  logic [IW-1:0]                alloc_idx,
   output logic                         take,
   output logic                         give,
   output logic [IW-1:0]                give_idx,
   output pdll_pkg::store_we_type       we,
   output logic [IW-1:0]                wr_addr,
   output logic [pdll_pkg::VALUE_W-1:0] wd_value,
   output logic [LW-1:0]                wd_next,
   output logic [LW-1:0]                wd_prev,
   output logic [IW-1:0]                rd_addr,
   input  logic [pdll_pkg::VALUE_W-1:0] rd_value,
   input  logic [LW-1:0]                rd_next,
   input  logic [LW-1:0]                rd_prev
);
   import pdll_pkg::*;

   localparam logic [LW-1:0] NIL = LW'(CAPACITY);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_DECODE   = 10'b0000000010,
      S_WALK     = 10'b0000000100,
      S_ACT      = 10'b0000001000,
      S_INS_NODE = 10'b0000010000,
      S_INS_LINK = 10'b0000100000,
      S_INS_PREV = 10'b0001000000,
      S_DEL_NEXT = 10'b0010000000,
      S_DEL_LINK = 10'b0100000000,
      S_RESULT   = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   status_type         status_ff, status_in;
   logic [LW-1:0]      cur_ff, cur_in;
   logic [LW-1:0]      after_ff, after_in;
   logic [LW-1:0]      prev_ff, prev_in;
   logic [LW-1:0]      new_ff, new_in;
   logic [LW-1:0]      steps_ff, steps_in;
   logic [LW-1:0]      head_ff, head_in;
   logic [LW-1:0]      tail_ff, tail_in;
   logic [POS_W:0]     pos_x;
   logic [POS_W:0]     cnt_x;

   assign pos_x = {1'b0, pos_ff};
   assign cnt_x = (POS_W + 1)'(count);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      value_in  = value_ff;
      status_in = status_ff;
      cur_in    = cur_ff;
      after_in  = after_ff;
      prev_in   = prev_ff;
      new_in    = new_ff;
      steps_in  = steps_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      take      = 1'b0;
      give      = 1'b0;
      give_idx  = cur_ff[IW-1:0];
      we        = '0;
      wr_addr   = cur_ff[IW-1:0];
      wd_value  = value_ff;
      wd_next   = after_ff;
      wd_prev   = cur_ff;
      rsp       = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               pos_in   = req_position;
               value_in = req_value;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            status_in = STATUS_OK;
            case (kind_ff)
               KIND_INS_HEAD: begin
                  if (full) begin
                     status_in = STATUS_FULL;
                     state_in  = S_RESULT;
                  end else begin
                     cur_in   = NIL;
                     after_in = head_ff;
                     state_in = S_INS_NODE;
                  end
               end
               KIND_INS_TAIL: begin
                  if (full) begin
                     status_in = STATUS_FULL;
                     state_in  = S_RESULT;
                  end else if (head_ff == NIL) begin
                     cur_in   = NIL;
                     after_in = NIL;
                     state_in = S_INS_NODE;
                  end else begin
                     cur_in   = tail_ff;
                     state_in = S_ACT;
                  end
               end
               KIND_INS_AT: begin
                  if (pos_ff == '0) begin
                     status_in = STATUS_INVALID;
                     state_in  = S_RESULT;
                  end else if (pos_ff == POS_W'(1)) begin
                     if (full) begin
                        status_in = STATUS_FULL;
                        state_in  = S_RESULT;
                     end else begin
                        cur_in   = NIL;
                        after_in = head_ff;
                        state_in = S_INS_NODE;
                     end
                  end else if (pos_x > cnt_x + (POS_W + 1)'(1)) begin
                     status_in = STATUS_RANGE;
                     state_in  = S_RESULT;
                  end else if (full) begin
                     status_in = STATUS_FULL;
                     state_in  = S_RESULT;
                  end else begin
                     cur_in   = head_ff;
                     steps_in = LW'(pos_ff - POS_W'(2));
                     state_in = (pos_ff == POS_W'(2)) ? S_ACT : S_WALK;
                  end
               end
               KIND_DEL_HEAD, KIND_DEL_TAIL: begin
                  if (head_ff == NIL) begin
                     status_in = STATUS_EMPTY;
                     state_in  = S_RESULT;
                  end else begin
                     cur_in   = (kind_ff == KIND_DEL_HEAD) ? head_ff : tail_ff;
                     state_in = S_ACT;
                  end
               end
               KIND_DEL_AT, KIND_UPDATE: begin
                  if (kind_ff == KIND_DEL_AT && head_ff == NIL) begin
                     status_in = STATUS_EMPTY;
                     state_in  = S_RESULT;
                  end else if (pos_ff == '0) begin
                     status_in = STATUS_INVALID;
                     state_in  = S_RESULT;
                  end else if (pos_x > cnt_x) begin
                     status_in = STATUS_RANGE;
                     state_in  = S_RESULT;
                  end else begin
                     cur_in   = head_ff;
                     steps_in = LW'(pos_ff - POS_W'(1));
                     state_in = (pos_ff == POS_W'(1)) ? S_ACT : S_WALK;
                  end
               end
               KIND_READ_ALL: begin
                  if (head_ff == NIL) begin
                     state_in = S_RESULT;
                  end else begin
                     cur_in   = head_ff;
                     state_in = S_ACT;
                  end
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end

         S_WALK: begin
            cur_in   = rd_next;
            steps_in = steps_ff - LW'(1);
            if (steps_ff == LW'(1)) begin
               state_in = S_ACT;
            end
         end

         S_ACT: begin
            case (kind_ff)
               KIND_INS_TAIL, KIND_INS_AT: begin
                  after_in = rd_next;
                  state_in = S_INS_NODE;
               end
               KIND_DEL_HEAD, KIND_DEL_TAIL, KIND_DEL_AT: begin
                  prev_in  = rd_prev;
                  after_in = rd_next;
                  state_in = S_DEL_NEXT;
               end
               KIND_UPDATE: begin
                  we.value = 1'b1;
                  state_in = S_RESULT;
               end
               KIND_READ_ALL: begin
                  if (out_free) begin
                     rsp.load          = 1'b1;
                     rsp.status        = STATUS_OK;
                     rsp.element_valid = 1'b1;
                     rsp.element       = rd_value;
                     rsp.last          = (rd_next == NIL);
                     if (rd_next == NIL) begin
                        state_in = S_IDLE;
                     end else begin
                        cur_in = rd_next;
                     end
                  end
               end
               default: begin
                  state_in = S_RESULT;
               end
            endcase
         end

         S_INS_NODE: begin
            wr_addr  = alloc_idx;
            we       = '{value: 1'b1, next: 1'b1, prev: 1'b1};
            new_in   = LW'(alloc_idx);
            state_in = S_INS_LINK;
         end

         S_INS_LINK: begin
            take = 1'b1;
            if (cur_ff != NIL) begin
               we.next = 1'b1;
               wd_next = new_ff;
            end else begin
               head_in = new_ff;
            end
            if (after_ff == NIL) begin
               tail_in  = new_ff;
               state_in = S_RESULT;
            end else begin
               state_in = S_INS_PREV;
            end
         end

         S_INS_PREV: begin
            wr_addr  = after_ff[IW-1:0];
            we.prev  = 1'b1;
            wd_prev  = new_ff;
            state_in = S_RESULT;
         end

         S_DEL_NEXT: begin
            if (after_ff != NIL) begin
               wr_addr = after_ff[IW-1:0];
               we.prev = 1'b1;
               wd_prev = prev_ff;
            end
            state_in = S_DEL_LINK;
         end

         S_DEL_LINK: begin
            give = 1'b1;
            if (prev_ff != NIL) begin
               wr_addr = prev_ff[IW-1:0];
               we.next = 1'b1;
               wd_next = after_ff;
            end else begin
               head_in = after_ff;
            end
            if (after_ff == NIL) begin
               tail_in = prev_ff;
            end
            state_in = S_RESULT;
         end

         S_RESULT: begin
            if (out_free) begin
               rsp.load   = 1'b1;
               rsp.status = status_ff;
               rsp.last   = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The read data in a cycle always belongs to the node held in cur_ff.
   assign rd_addr = cur_in[IW-1:0];
   assign ready   = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= NIL;
         tail_ff  <= NIL;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      cur_ff    <= cur_in;
      after_ff  <= after_in;
      prev_ff   <= prev_in;
      new_ff    <= new_in;
      steps_ff  <= steps_in;
   end

   `PDLL_ASSERT(a_head_tracks_count, clock, reset, (head_ff == NIL) == (count == '0), "Head pointer disagrees with node count.")
   `PDLL_ASSERT(a_tail_tracks_head, clock, reset, (tail_ff == NIL) == (head_ff == NIL), "Tail pointer disagrees with head pointer.")
   `PDLL_ASSERT_IMPL(a_walk_has_steps, clock, reset, state_ff == S_WALK, steps_ff != '0, "Link walk entered with no steps left.")

endmodule
`default_nettype wire

### src/positional_doubly_linked_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional doubly linked list
// Ordered list of signed 32-bit values kept as a doubly linked list in a
// node store with a free map; inserts, deletes, updates and read-out.
//
//   Group  Dir  tdata                          tuser          tlast
//   req_   in   position[7:0], value[39:8]     kind[2:0]      -
//   rsp_   out  status[2:0], element[34:3]     element_valid  last result
//
// After acceptance req_tready stays low until the last response of the
// operation is loaded; a positional walk follows one link per cycle
// through the single read port of the node store. A read-out delivers
// one element per cycle while rsp_tready stays high. Reset clears the
// free map and the head and tail pointers; the store needs no clearing.
// The result register holds a transaction while rsp_tready is low.
// ----------------------------------------------------------------------------
module positional_doubly_linked_list #(
   parameter int CAPACITY = pdll_pkg::CAPACITY_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // position [7:0], value [39:8]
   input  logic [pdll_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind [2:0]
   input  logic [pdll_pkg::KIND_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [2:0], element [34:3], zero [39:35]
   output logic [pdll_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // element_valid [0]
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);
   import pdll_pkg::*;

   localparam int LW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic               start;
   logic               ready;
   logic               out_free;
   rsp_type            rsp;
   logic [LW-1:0]      count;
   logic               full;
   logic [IW-1:0]      alloc_idx;
   logic               take;
   logic               give;
   logic [IW-1:0]      give_idx;
   store_we_type       we;
   logic [IW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wd_value;
   logic [LW-1:0]      wd_next;
   logic [LW-1:0]      wd_prev;
   logic [IW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_value;
   logic [LW-1:0]      rd_next;
   logic [LW-1:0]      rd_prev;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         rsp_status_ff;
   logic               rsp_el_valid_ff;
   logic [VALUE_W-1:0] rsp_element_ff;
   logic               rsp_last_ff;

   assign req_tready = ready;
   assign start      = req_tvalid && ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   pdll_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_kind     (kind_type'(req_tuser)),
      .req_position (req_tdata[POS_W-1:0]),
      .req_value    (req_tdata[POS_W+VALUE_W-1:POS_W]),
      .ready        (ready),
      .out_free     (out_free),
      .rsp          (rsp),
      .count        (count),
      .full         (full),
      .alloc_idx    (alloc_idx),
      .take         (take),
      .give         (give),
      .give_idx     (give_idx),
      .we           (we),
      .wr_addr      (wr_addr),
      .wd_value     (wd_value),
      .wd_next      (wd_next),
      .wd_prev      (wd_prev),
      .rd_addr      (rd_addr),
      .rd_value     (rd_value),
      .rd_next      (rd_next),
      .rd_prev      (rd_prev)
   );

   pdll_freemap #(
      .CAPACITY (CAPACITY)
   ) u_freemap (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .give      (give),
      .give_idx  (give_idx),
      .alloc_idx (alloc_idx),
      .count     (count),
      .full      (full)
   );

   pdll_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock    (clock),
      .we       (we),
      .wr_addr  (wr_addr),
      .wd_value (wd_value),
      .wd_next  (wd_next),
      .wd_prev  (wd_prev),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_next  (rd_next),
      .rd_prev  (rd_prev)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.load) begin
         rsp_status_ff   <= rsp.status;
         rsp_el_valid_ff <= rsp.element_valid;
         rsp_element_ff  <= rsp.element;
         rsp_last_ff     <= rsp.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - STATUS_W - VALUE_W)'(0), rsp_element_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_el_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

### dv/positional_doubly_linked_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional doubly linked list testbench
// Sends list operations over the request stream and keeps an ordered copy of
// the list to work out every response transaction. Each response is checked
// field by field in arrival order. Directed tests cover the empty list, bad
// positions, value extremes and a full store, then random traffic grows and
// shrinks the list under changing valid and ready gaps.
// ----------------------------------------------------------------------------
module positional_doubly_linked_list_tb;
   import pdll_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      status_type         status;
      logic               element_valid;
      logic [VALUE_W-1:0] element;
      logic               last;
   } list_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   logic [VALUE_W-1:0] list_contents[$];
   list_result_type    pending_results[$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 send_idle_pct = 31;
   int                 rsp_stall_pct = 75;
   bit                 grow_bias = 1'b1;

   positional_doubly_linked_list #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic void push_result(status_type status, logic element_valid,
                                       logic [VALUE_W-1:0] element, logic last);
      list_result_type r;
      r.status        = status;
      r.element_valid = element_valid;
      r.element       = element;
      r.last          = last;
      pending_results.push_back(r);
   endfunction

   // Applies one operation to the list copy and queues the responses it causes.
   function automatic void predict_list_op(kind_type kind, logic [POS_W-1:0] pos,
                                           logic [VALUE_W-1:0] val);
      status_type st;
      int         len;
      int         k;
      st  = STATUS_OK;
      len = list_contents.size();
      k   = pos;
      case (kind)
         KIND_INS_HEAD: begin
            if (len >= CAPACITY) st = STATUS_FULL;
            else list_contents.push_front(val);
         end
         KIND_INS_TAIL: begin
            if (len >= CAPACITY) st = STATUS_FULL;
            else list_contents.push_back(val);
         end
         KIND_INS_AT: begin
            if (k == 0) st = STATUS_INVALID;
            else if (k > len + 1) st = STATUS_RANGE;
            else if (len >= CAPACITY) st = STATUS_FULL;
            else list_contents.insert(k - 1, val);
         end
         KIND_DEL_HEAD: begin
            if (len == 0) st = STATUS_EMPTY;
            else void'(list_contents.pop_front());
         end
         KIND_DEL_TAIL: begin
            if (len == 0) st = STATUS_EMPTY;
            else void'(list_contents.pop_back());
         end
         KIND_DEL_AT: begin
            if (len == 0) st = STATUS_EMPTY;
            else if (k == 0) st = STATUS_INVALID;
            else if (k > len) st = STATUS_RANGE;
            else list_contents.delete(k - 1);
         end
         KIND_UPDATE: begin
            if (k == 0) st = STATUS_INVALID;
            else if (k > len) st = STATUS_RANGE;
            else list_contents[k - 1] = val;
         end
         default: begin
         end
      endcase
      if (kind == KIND_READ_ALL && len != 0) begin
         for (int i = 0; i < len; i++)
            push_result(STATUS_OK, 1'b1, list_contents[i], i == len - 1);
      end else begin
         push_result(st, 1'b0, '0, 1'b1);
      end
   endfunction

   task automatic send_list_op(input kind_type kind, input logic [POS_W-1:0] pos,
                               input logic [VALUE_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {val, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_list_op(kind, pos, val);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response transaction: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[2:0] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[2:0]);
               error_count++;
            end
            if (rsp_tuser !== want.element_valid) begin
               $error("element_valid: expected %0d, actual %0d", want.element_valid,
                      rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[34:3] !== want.element) begin
               $error("element: expected %0d, actual %0d", $signed(want.element),
                      $signed(rsp_tdata[34:3]));
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[39:35] !== '0) begin
               $error("tdata padding: expected 0, actual %h", rsp_tdata[39:35]);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_list();
      send_list_op(KIND_READ_ALL, 8'd0, '0);
      send_list_op(KIND_DEL_HEAD, 8'd0, '0);
      send_list_op(KIND_DEL_TAIL, 8'd0, '0);
      send_list_op(KIND_DEL_AT, 8'd0, '0);
      send_list_op(KIND_UPDATE, 8'd1, 32'h1234_5678);
      send_list_op(KIND_INS_AT, 8'd0, 32'h1);
      send_list_op(KIND_INS_AT, 8'd2, 32'h2);
   endtask

   task automatic test_positions_and_extremes();
      send_list_op(KIND_INS_AT, 8'd1, 32'h7fff_ffff);
      send_list_op(KIND_INS_HEAD, 8'hff, 32'h8000_0000);
      send_list_op(KIND_INS_TAIL, 8'h00, 32'hffff_ffff);
      send_list_op(KIND_INS_AT, 8'd4, 32'h0);
      send_list_op(KIND_INS_AT, 8'd2, 32'h5555_aaaa);
      send_list_op(KIND_DEL_AT, 8'd0, '0);
      send_list_op(KIND_DEL_AT, 8'hff, '0);
      send_list_op(KIND_UPDATE, 8'd0, 32'h1);
      send_list_op(KIND_UPDATE, 8'hff, 32'h1);
      send_list_op(KIND_UPDATE, 8'd3, 32'haaaa_5555);
      send_list_op(KIND_DEL_AT, 8'd2, '0);
      send_list_op(KIND_READ_ALL, 8'h00, '0);
   endtask

   task automatic test_full_store();
      while (list_contents.size() < CAPACITY)
         send_list_op(KIND_INS_TAIL, 8'(list_contents.size()), $urandom());
      send_list_op(KIND_INS_HEAD, 8'd0, $urandom());
      send_list_op(KIND_INS_TAIL, 8'd0, $urandom());
      send_list_op(KIND_INS_AT, 8'd1, $urandom());
      send_list_op(KIND_INS_AT, 8'(CAPACITY + 1), $urandom());
      // The range check wins over the full check.
      send_list_op(KIND_INS_AT, 8'(CAPACITY + 2), $urandom());
      send_list_op(KIND_READ_ALL, 8'd0, '0);
      send_list_op(KIND_DEL_TAIL, 8'd0, '0);
      send_list_op(KIND_DEL_AT, 8'(CAPACITY - 1), '0);
   endtask

   task automatic test_random_traffic(input int count);
      kind_type           kind;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] val;
      int                 r;
      int                 len;
      for (int n = 0; n < count; n++) begin
         len = list_contents.size();
         if (len >= CAPACITY && $urandom_range(3) == 0) grow_bias = 1'b0;
         else if (len == 0 && $urandom_range(1) == 0) grow_bias = 1'b1;
         else if ($urandom_range(31) == 0) grow_bias = !grow_bias;
         r = $urandom_range(99);
         if (r < 5)
            kind = kind_type'($urandom_range(KIND_INS_HEAD, KIND_READ_ALL));
         else if (r < (grow_bias ? 70 : 25))
            kind = kind_type'($urandom_range(KIND_INS_HEAD, KIND_INS_AT));
         else if (r < 80)
            kind = kind_type'($urandom_range(KIND_DEL_HEAD, KIND_DEL_AT));
         else if (r < 90)
            kind = KIND_UPDATE;
         else
            kind = KIND_READ_ALL;
         if ($urandom_range(99) < 85) pos = 8'($urandom_range(0, len + 1));
         else pos = 8'($urandom_range(0, 255));
         case ($urandom_range(15))
            0: val = 32'h7fff_ffff;
            1: val = 32'h8000_0000;
            default: val = $urandom();
         endcase
         send_list_op(kind, pos, val);
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 31;
      rsp_stall_pct = 75;
      test_empty_list();
      test_positions_and_extremes();
      test_full_store();
      test_random_traffic(91);

      send_idle_pct = 75;
      rsp_stall_pct = 31;
      test_random_traffic(90);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      test_random_traffic(90);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (CAPACITY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
